>>> rtl/core/vps_pkg.sv
// vps_pkg: shared types, widths and register codes for the Verlet point step.
// No dependencies; used by every module under rtl/core.
package vps_pkg;

   localparam int POS_W       = 24;   // Q16.8 positions
   localparam int VEL_W       = 26;   // position difference, Q18.8
   localparam int COORD_W     = 12;   // pointer coordinates, whole pixels
   localparam int ACCEL_W     = 24;   // Q8.16 acceleration step
   localparam int COEF_W      = 17;   // Q1.16 coefficients
   localparam int PIX_W       = 8;    // touch limit and pick radius
   localparam int SIZE_W      = 13;   // field size in pixels
   localparam int AXES        = 2;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [COEF_W-1:0] ONE_Q16  = COEF_W'(65536);
   localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(2);

   typedef enum logic [2:0] {
      REG_ACCEL_X = 3'd0,
      REG_ACCEL_Y = 3'd1,
      REG_AIR     = 3'd2,
      REG_BOUNCE  = 3'd3,
      REG_TOUCH   = 3'd4,
      REG_RANGE   = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] prev_x;
      logic signed [POS_W-1:0] prev_y;
      logic signed [POS_W-1:0] anchor_x;
      logic signed [POS_W-1:0] anchor_y;
      logic                    pinned;
      logic [COORD_W-1:0]      pointer_x;
      logic [COORD_W-1:0]      pointer_y;
      logic [COORD_W-1:0]      pointer_last_x;
      logic [COORD_W-1:0]      pointer_last_y;
      logic                    button_down;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] new_pos_x;
      logic signed [POS_W-1:0] new_pos_y;
      logic signed [POS_W-1:0] new_prev_x;
      logic signed [POS_W-1:0] new_prev_y;
      logic                    selected;
   } rsp_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_step_x;
      logic signed [ACCEL_W-1:0] accel_step_y;
      logic [COEF_W-1:0]         damp_frac;
      logic [COEF_W-1:0]         bounce;
      logic [PIX_W-1:0]          touch_limit;
      logic [PIX_W-1:0]          pick_radius;
      logic [SIZE_W-1:0]         field_width;
      logic [SIZE_W-1:0]         field_height;
   } cfg_type;

   // One classified point, handed from front to back. Index 0 is x, 1 is y.
   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0] pos;
      logic [AXES-1:0][VEL_W-1:0] vel;
      logic [AXES-1:0][POS_W-1:0] anchor;
      logic                       pinned;
      logic                       selected;
   } work_type;

endpackage

>>> rtl/core/vps_csr.sv
// vps_csr: APB-style register file for the Verlet point step.
// Depends on vps_pkg.
module vps_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [vps_pkg::ADDR_W-1:0] paddr,
   input  logic [vps_pkg::DATA_W-1:0] pwdata,
   output logic [vps_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output vps_pkg::cfg_type           cfg
);

   vps_pkg::cfg_type       cfg_ff, cfg_in;
   vps_pkg::reg_index_type index;
   logic                   wr_en;
   logic [vps_pkg::COEF_W-1:0] coef_wr;
   logic [vps_pkg::SIZE_W-1:0] size_wr;

   assign index   = vps_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign coef_wr = (pwdata[vps_pkg::COEF_W-1:0] > vps_pkg::ONE_Q16) ?
                    vps_pkg::ONE_Q16 : pwdata[vps_pkg::COEF_W-1:0];
   assign size_wr = (pwdata[vps_pkg::SIZE_W-1:0] < vps_pkg::MIN_SIZE) ?
                    vps_pkg::MIN_SIZE : pwdata[vps_pkg::SIZE_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            vps_pkg::REG_ACCEL_X: cfg_in.accel_step_x = pwdata[vps_pkg::ACCEL_W-1:0];
            vps_pkg::REG_ACCEL_Y: cfg_in.accel_step_y = pwdata[vps_pkg::ACCEL_W-1:0];
            vps_pkg::REG_AIR:     cfg_in.damp_frac    = coef_wr;
            vps_pkg::REG_BOUNCE:  cfg_in.bounce       = coef_wr;
            vps_pkg::REG_TOUCH:   cfg_in.touch_limit  = pwdata[vps_pkg::PIX_W-1:0];
            vps_pkg::REG_RANGE:   cfg_in.pick_radius  = pwdata[vps_pkg::PIX_W-1:0];
            vps_pkg::REG_WIDTH:   cfg_in.field_width  = size_wr;
            vps_pkg::REG_HEIGHT:  cfg_in.field_height = size_wr;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_step_x <= '0;
         cfg_ff.accel_step_y <= '0;
         cfg_ff.damp_frac    <= '0;
         cfg_ff.bounce       <= vps_pkg::COEF_W'(32768);
         cfg_ff.touch_limit  <= vps_pkg::PIX_W'(10);
         cfg_ff.pick_radius  <= vps_pkg::PIX_W'(20);
         cfg_ff.field_width  <= vps_pkg::SIZE_W'(800);
         cfg_ff.field_height <= vps_pkg::SIZE_W'(600);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         vps_pkg::REG_ACCEL_X: prdata = vps_pkg::DATA_W'(cfg_ff.accel_step_x);
         vps_pkg::REG_ACCEL_Y: prdata = vps_pkg::DATA_W'(cfg_ff.accel_step_y);
         vps_pkg::REG_AIR:     prdata = vps_pkg::DATA_W'(cfg_ff.damp_frac);
         vps_pkg::REG_BOUNCE:  prdata = vps_pkg::DATA_W'(cfg_ff.bounce);
         vps_pkg::REG_TOUCH:   prdata = vps_pkg::DATA_W'(cfg_ff.touch_limit);
         vps_pkg::REG_RANGE:   prdata = vps_pkg::DATA_W'(cfg_ff.pick_radius);
         vps_pkg::REG_WIDTH:   prdata = vps_pkg::DATA_W'(cfg_ff.field_width);
         vps_pkg::REG_HEIGHT:  prdata = vps_pkg::DATA_W'(cfg_ff.field_height);
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/vps_front.sv
// vps_front: three-stage front end; pointer pick test and drag velocity.
// Depends on vps_pkg.
module vps_front (
   input  logic              clock,
   input  logic              reset,
   input  vps_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  vps_pkg::req_type  req_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vps_pkg::work_type out_data
);

   localparam int DX_W  = vps_pkg::POS_W + 1;
   localparam int MV_W  = vps_pkg::COORD_W + 1;
   localparam int SQ_W  = 2 * DX_W;
   localparam int SUM_W = 49;
   localparam int RR_W  = 2 * vps_pkg::PIX_W;

   logic en;

   // stage 1
   logic                    v1_ff;
   vps_pkg::req_type        r1_ff;
   logic signed [DX_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic signed [MV_W-1:0]  cx_ff, cy_ff, cx_in, cy_in;
   logic signed [MV_W-1:0]  mdx, mdy, lim;

   // stage 2
   logic                           v2_ff;
   vps_pkg::req_type               r2_ff;
   logic signed [SQ_W-1:0]         sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [RR_W-1:0]                rr2_ff, rr2_in;
   logic signed [vps_pkg::VEL_W-1:0] vpx_ff, vpy_ff, vpx_in, vpy_in;
   logic signed [vps_pkg::VEL_W-1:0] vdx_ff, vdy_ff, vdx_in, vdy_in;

   // stage 3
   logic              v3_ff;
   vps_pkg::work_type w3_ff, w3_in;
   logic [SUM_W-1:0]  dist2;
   logic              sel, drag;

   assign en        = !v3_ff || out_ready;
   assign req_ready = en;

   always_comb begin
      dx_in = $signed({req_data.pos_x[vps_pkg::POS_W-1], req_data.pos_x}) -
              $signed({5'b0, req_data.pointer_x, 8'b0});
      dy_in = $signed({req_data.pos_y[vps_pkg::POS_W-1], req_data.pos_y}) -
              $signed({5'b0, req_data.pointer_y, 8'b0});
      mdx   = $signed({1'b0, req_data.pointer_x}) - $signed({1'b0, req_data.pointer_last_x});
      mdy   = $signed({1'b0, req_data.pointer_y}) - $signed({1'b0, req_data.pointer_last_y});
      lim   = $signed({5'b0, cfg.touch_limit});
      cx_in = (mdx > lim) ? lim : ((mdx < -lim) ? -lim : mdx);
      cy_in = (mdy > lim) ? lim : ((mdy < -lim) ? -lim : mdy);
   end

   always_comb begin
      sqx_in = dx_ff * dx_ff;
      sqy_in = dy_ff * dy_ff;
      rr2_in = cfg.pick_radius * cfg.pick_radius;
      vpx_in = vps_pkg::VEL_W'(r1_ff.pos_x) - vps_pkg::VEL_W'(r1_ff.prev_x);
      vpy_in = vps_pkg::VEL_W'(r1_ff.pos_y) - vps_pkg::VEL_W'(r1_ff.prev_y);
      // a dragged point's velocity is the clamped pointer move itself
      vdx_in = vps_pkg::VEL_W'($signed({cx_ff, 8'b0}));
      vdy_in = vps_pkg::VEL_W'($signed({cy_ff, 8'b0}));
   end

   always_comb begin
      dist2 = SUM_W'(sqx_ff[SUM_W-2:0]) + SUM_W'(sqy_ff[SUM_W-2:0]);
      sel   = dist2 < {17'b0, rr2_ff, 16'b0};
      drag  = sel && r2_ff.button_down;
      w3_in.pos[0]    = r2_ff.pos_x;
      w3_in.pos[1]    = r2_ff.pos_y;
      w3_in.vel[0]    = drag ? vdx_ff : vpx_ff;
      w3_in.vel[1]    = drag ? vdy_ff : vpy_ff;
      w3_in.anchor[0] = r2_ff.anchor_x;
      w3_in.anchor[1] = r2_ff.anchor_y;
      w3_in.pinned    = r2_ff.pinned;
      w3_in.selected  = sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff  <= req_data;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         r2_ff  <= r1_ff;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         rr2_ff <= rr2_in;
         vpx_ff <= vpx_in;
         vpy_ff <= vpy_in;
         vdx_ff <= vdx_in;
         vdy_ff <= vdy_in;
         w3_ff  <= w3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = w3_ff;

endmodule

>>> rtl/core/vps_queue.sv
// vps_queue: small flop-based FIFO between front and back.
// Depends on vps_pkg.
module vps_queue #(
   parameter int DEPTH = vps_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vps_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vps_pkg::work_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vps_pkg::work_type  mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/core/vps_back.sv
// vps_back: six-stage integrator; damped Verlet step, bound clamp with bounce,
// pin override and saturation. Depends on vps_pkg.
module vps_back (
   input  logic              clock,
   input  logic              reset,
   input  vps_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  vps_pkg::work_type in_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vps_pkg::rsp_type  rsp_data
);

   localparam int T_W   = vps_pkg::VEL_W + 9;         // v*256 + accel
   localparam int S_W   = T_W + vps_pkg::COEF_W + 1;  // times damping
   localparam int R_W   = S_W - 24;                   // step after rounding
   localparam int NP_W  = R_W + 1;
   localparam int HI_W  = vps_pkg::SIZE_W + 8;
   localparam int M_W   = R_W + vps_pkg::COEF_W + 1;
   localparam int RB_W  = M_W - 16;
   localparam int NPV_W = RB_W + 1;

   localparam logic signed [S_W-1:0]  HALF_S   = S_W'(1) <<< 23;
   localparam logic signed [M_W-1:0]  HALF_M   = M_W'(1) <<< 15;
   localparam logic signed [NP_W-1:0] LO_BOUND = NP_W'(256);
   localparam logic signed [NPV_W-1:0] SAT_HI  = NPV_W'(8388607);
   localparam logic signed [NPV_W-1:0] SAT_LO  = -NPV_W'(8388608);

   function automatic logic [vps_pkg::POS_W-1:0] sat24(input logic signed [NPV_W-1:0] x);
      logic [vps_pkg::POS_W-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[vps_pkg::POS_W-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[vps_pkg::POS_W-1:0];
      end else begin
         r = x[vps_pkg::POS_W-1:0];
      end
      return r;
   endfunction

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   vps_pkg::work_type w1_ff, w2_ff, w3_ff, w4_ff, w5_ff;
   vps_pkg::rsp_type  rsp_ff, rsp_in;

   logic signed [vps_pkg::ACCEL_W-1:0] accel [vps_pkg::AXES];
   logic [vps_pkg::SIZE_W-1:0]         size  [vps_pkg::AXES];
   logic [vps_pkg::COEF_W-1:0]         damp;

   logic signed [T_W-1:0]   t_ff   [vps_pkg::AXES], t_in   [vps_pkg::AXES];
   logic signed [S_W-1:0]   s_ff   [vps_pkg::AXES], s_in   [vps_pkg::AXES];
   logic signed [R_W-1:0]   r3_ff  [vps_pkg::AXES], r3_in  [vps_pkg::AXES];
   logic signed [R_W-1:0]   r4_ff  [vps_pkg::AXES];
   logic signed [NP_W-1:0]  np_ff  [vps_pkg::AXES], np_in  [vps_pkg::AXES];
   logic signed [NP_W-1:0]  npc4_ff [vps_pkg::AXES], npc_in [vps_pkg::AXES];
   logic signed [NP_W-1:0]  npc5_ff [vps_pkg::AXES];
   logic                    hit4_ff [vps_pkg::AXES], hit_in [vps_pkg::AXES];
   logic                    hit5_ff [vps_pkg::AXES];
   logic signed [M_W-1:0]   m_ff   [vps_pkg::AXES], m_in   [vps_pkg::AXES];
   logic [HI_W-1:0]         hi     [vps_pkg::AXES];
   logic signed [RB_W-1:0]  rb     [vps_pkg::AXES];
   logic signed [NPV_W-1:0] npv    [vps_pkg::AXES];
   logic [vps_pkg::POS_W-1:0] pos_o [vps_pkg::AXES], prev_o [vps_pkg::AXES];

   assign en       = !v6_ff || rsp_ready;
   assign in_ready = en;

   assign accel[0] = cfg.accel_step_x;
   assign accel[1] = cfg.accel_step_y;
   assign size[0]  = cfg.field_width;
   assign size[1]  = cfg.field_height;
   assign damp     = vps_pkg::ONE_Q16 - cfg.damp_frac;

   always_comb begin
      for (int a = 0; a < vps_pkg::AXES; a++) begin
         // B1: v in Q.16 plus acceleration
         t_in[a]   = T_W'($signed({in_data.vel[a], 8'b0})) + T_W'(accel[a]);
         // B2: damping multiply
         s_in[a]   = t_ff[a] * $signed({1'b0, damp});
         // B3: round to Q16.8 and step
         r3_in[a]  = R_W'((s_ff[a] + HALF_S) >>> 24);
         np_in[a]  = NP_W'($signed(w2_ff.pos[a])) + NP_W'(r3_in[a]);
         // B4: bound clamp; the pre-clamp move equals the rounded step
         hi[a]     = {size[a] - 1'b1, 8'b0};
         hit_in[a] = (np_ff[a] > $signed({1'b0, hi[a]})) || (np_ff[a] < LO_BOUND);
         if (np_ff[a] > $signed({1'b0, hi[a]})) begin
            npc_in[a] = NP_W'($signed({1'b0, hi[a]}));
         end else if (np_ff[a] < LO_BOUND) begin
            npc_in[a] = LO_BOUND;
         end else begin
            npc_in[a] = np_ff[a];
         end
         // B5: bounce multiply
         m_in[a]   = r4_ff[a] * $signed({1'b0, cfg.bounce});
         // B6: reflect previous position, pin override, saturate
         rb[a]     = RB_W'((m_ff[a] + HALF_M) >>> 16);
         npv[a]    = NPV_W'(npc5_ff[a]) + NPV_W'(rb[a]);
         prev_o[a] = hit5_ff[a] ? sat24(npv[a]) : w5_ff.pos[a];
         pos_o[a]  = w5_ff.pinned ? w5_ff.anchor[a] : sat24(NPV_W'(npc5_ff[a]));
      end
      rsp_in.new_pos_x  = pos_o[0];
      rsp_in.new_pos_y  = pos_o[1];
      rsp_in.new_prev_x = prev_o[0];
      rsp_in.new_prev_y = prev_o[1];
      rsp_in.selected   = w5_ff.selected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff  <= in_data;
         w2_ff  <= w1_ff;
         w3_ff  <= w2_ff;
         w4_ff  <= w3_ff;
         w5_ff  <= w4_ff;
         rsp_ff <= rsp_in;
         for (int a = 0; a < vps_pkg::AXES; a++) begin
            t_ff[a]    <= t_in[a];
            s_ff[a]    <= s_in[a];
            r3_ff[a]   <= r3_in[a];
            np_ff[a]   <= np_in[a];
            r4_ff[a]   <= r3_ff[a];
            npc4_ff[a] <= npc_in[a];
            hit4_ff[a] <= hit_in[a];
            m_ff[a]    <= m_in[a];
            npc5_ff[a] <= npc4_ff[a];
            hit5_ff[a] <= hit4_ff[a];
         end
      end
   end

   assign rsp_valid = v6_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/verlet_point_step.sv
// verlet_point_step: one damped position-Verlet step per cloth point.
// Each point passes the front stages, the queue and the back stages; one point
// per cycle while rsp_ready holds, set by the pipelined pick-radius squares and
// the damping and bounce multipliers (one per stage per axis).
// Synchronous active-high reset empties the pipelines and queue and loads the
// register defaults; configuration is taken at any time on the APB port.
module verlet_point_step #(
   parameter int QUEUE_DEPTH = vps_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // point input channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  vps_pkg::req_type           req_data,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output vps_pkg::rsp_type           rsp_data,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [vps_pkg::ADDR_W-1:0] paddr,
   input  logic [vps_pkg::DATA_W-1:0] pwdata,
   output logic [vps_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   vps_pkg::cfg_type  cfg;
   vps_pkg::work_type front_data, back_data;
   logic              front_valid, front_ready;
   logic              back_valid, back_ready;

   // Registers at byte address 4*i: accel x/y, air friction, bounce,
   // touch limit, pick radius, field width, field height. Coefficients
   // saturate at 1.0 and field sizes at 2 when written.
   vps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Front: squared-distance pick test against the pointer, then choice of
   // velocity (stored motion, or clamped pointer move for a dragged point).
   vps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Queue decouples the two halves: the front keeps taking points while a
   // stalled result holds the back, until the queue fills.
   vps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   // Back: Verlet step with damping, clamp to [1, size-1] with bounce
   // reflection of the previous position, pin override, 24-bit saturation.
   // Its last stage is the output register.
   vps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_data   (back_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
